### src/btbstat_pkg.sv
`default_nettype none

package btbstat_pkg;

  // Store geometry and field widths.
  localparam int MAX_INDEX_BITS = 7;
  localparam int COUNT_WIDTH    = 48;
  localparam int PC_WIDTH       = 32;
  localparam int WORD_SHIFT     = 2;
  localparam int TAG_WIDTH      = PC_WIDTH - WORD_SHIFT;
  localparam int STORE_DEPTH    = 1 << MAX_INDEX_BITS;
  localparam int CFG_WIDTH      = 3;

  localparam logic [CFG_WIDTH-1:0] INDEX_BITS_RESET = CFG_WIDTH'(4);

  typedef logic [PC_WIDTH-1:0]       pc_t;
  typedef logic [TAG_WIDTH-1:0]      tag_t;
  typedef logic [MAX_INDEX_BITS-1:0] idx_t;
  typedef logic [COUNT_WIDTH-1:0]    count_t;
  typedef logic [CFG_WIDTH-1:0]      cfg_t;

  // Increment that holds at the all-ones value.
  function automatic count_t sat_inc(input count_t v);
    sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

`default_nettype wire

### src/btbstat_if.sv
`default_nettype none

// Branch transaction channel.
interface btbstat_in_if;
  import btbstat_pkg::*;

  logic valid;
  logic ready;
  pc_t  branch_pc;
  pc_t  target_pc;
  logic was_taken;

  modport source (output valid, output branch_pc, output target_pc, output was_taken,
                  input ready);
  modport sink   (input valid, input branch_pc, input target_pc, input was_taken,
                  output ready);
endinterface

// Result transaction channel.
interface btbstat_out_if;
  import btbstat_pkg::*;

  logic   valid;
  logic   ready;
  logic   tag_hit;
  logic   predicted_taken;
  logic   prediction_correct;
  count_t branches_seen;
  count_t tag_hits_total;
  count_t correct_total;

  modport source (output valid, output tag_hit, output predicted_taken,
                  output prediction_correct, output branches_seen,
                  output tag_hits_total, output correct_total, input ready);
  modport sink   (input valid, input tag_hit, input predicted_taken,
                  input prediction_correct, input branches_seen,
                  input tag_hits_total, input correct_total, output ready);
endinterface

`default_nettype wire

### src/btbstat_ram.sv
`default_nettype none

// Simple dual-port RAM with a registered read; a read of the address being
// written in the same cycle returns the old contents.
module btbstat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/btb_tag_hit_btfn_predict_stats.sv
`default_nettype none

// Direct-mapped branch target buffer with backward-taken / forward-not-taken
// prediction and saturating statistics. Each branch transaction is looked up
// in a 128-entry tag store indexed by the low index_bits bits of the word
// address; a hit scores the prediction, a miss installs the tag. One branch
// is accepted every cycle unless a waiting result stalls; each goes through
// the lookup stage into the result register. The tag RAM read is registered
// at the same edge as the lookup stage; the compare and update go into the
// result register as the lookup stage advances. A waiting result holds the
// lookup stage, and the branch channel once that stage is full. A write to
// the index register must be made while no transaction is in flight; it
// does not clear the store. The valid bits are flip-flops cleared by reset.
module btb_tag_hit_btfn_predict_stats (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire btbstat_pkg::cfg_t       cfg_wdata,
  btbstat_in_if.sink                   branch,
  btbstat_out_if.source                result
);
  import btbstat_pkg::*;

  cfg_t index_bits;

  // Lookup stage registers.
  logic s1_valid;
  pc_t  s1_pc;
  pc_t  s1_target;
  logic s1_taken;
  idx_t s1_idx;
  tag_t s1_tag;
  logic s1_fwd;
  tag_t s1_fwd_tag;

  // State and counters.
  logic [STORE_DEPTH-1:0] valid_bits;
  count_t seen_cnt;
  count_t hit_cnt;
  count_t correct_cnt;

  logic accept;
  logic advance;
  cfg_t eff_bits;
  tag_t in_word;
  tag_t in_masked;
  idx_t in_idx;
  tag_t in_tag;
  tag_t ram_rdata;
  tag_t stored_tag;
  logic hit;
  logic pred;
  logic correct;
  logic wr_en;
  count_t seen_next;
  count_t hit_next;
  count_t correct_next;

  // Index register.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= INDEX_BITS_RESET;
    end else if (cfg_we) begin
      index_bits <= cfg_wdata;
    end
  end

  // Split the word address into index and tag.
  always_comb begin
    eff_bits  = (index_bits > CFG_WIDTH'(MAX_INDEX_BITS)) ? CFG_WIDTH'(MAX_INDEX_BITS)
                                                          : index_bits;
    in_word   = branch.branch_pc[PC_WIDTH-1:WORD_SHIFT];
    in_masked = in_word & ~({TAG_WIDTH{1'b1}} << eff_bits);
    in_idx    = in_masked[MAX_INDEX_BITS-1:0];
    in_tag    = in_word >> eff_bits;
  end

  // Handshake: the lookup stage moves on whenever the result register is free.
  assign advance      = s1_valid && (!result.valid || result.ready);
  assign branch.ready = !s1_valid || advance;
  assign accept       = branch.valid && branch.ready;

  btbstat_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_tags (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx),
    .wdata (s1_tag),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // Compare, predict and score. A tag written in the cycle of this
  // transaction's read is taken from the bypass copy.
  always_comb begin
    stored_tag   = s1_fwd ? s1_fwd_tag : ram_rdata;
    hit          = valid_bits[s1_idx] && (stored_tag == s1_tag);
    pred         = s1_target < s1_pc;
    correct      = hit && (pred == s1_taken);
    wr_en        = advance && !hit;
    seen_next    = sat_inc(seen_cnt);
    hit_next     = hit ? sat_inc(hit_cnt) : hit_cnt;
    correct_next = correct ? sat_inc(correct_cnt) : correct_cnt;
  end

  // Lookup stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pc      <= branch.branch_pc;
      s1_target  <= branch.target_pc;
      s1_taken   <= branch.was_taken;
      s1_idx     <= in_idx;
      s1_tag     <= in_tag;
      s1_fwd     <= wr_en && (s1_idx == in_idx);
      s1_fwd_tag <= s1_tag;
    end
  end

  // Valid bits and counters update as a transaction leaves the lookup stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits  <= '0;
      seen_cnt    <= '0;
      hit_cnt     <= '0;
      correct_cnt <= '0;
    end else if (advance) begin
      if (!hit) begin
        valid_bits[s1_idx] <= 1'b1;
      end
      seen_cnt    <= seen_next;
      hit_cnt     <= hit_next;
      correct_cnt <= correct_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.tag_hit            <= hit;
      result.predicted_taken    <= pred;
      result.prediction_correct <= correct;
      result.branches_seen      <= seen_next;
      result.tag_hits_total     <= hit_next;
      result.correct_total      <= correct_next;
    end
  end

endmodule

`default_nettype wire
